>>> rtl/bdiv_pkg.sv
// bdiv_pkg: request and response types, clock-word field codes and lookup tables
// for the baud divisor block; no dependencies
package bdiv_pkg;

    localparam int CFG_W      = 32;
    localparam int HZ_W       = 28;
    localparam int ADC_W      = 27;
    localparam int BAUD_W     = 23;
    localparam int DIV_W      = 16;
    localparam int NUM_W      = 33;
    localparam int DEN_W      = 25;
    localparam int CENT_W     = 7;

    localparam logic [1:0] SRC_EXT = 2'd1;
    localparam logic [1:0] SRC_PLL = 2'd2;

    localparam logic [1:0] ADC_DIV2 = 2'd0;
    localparam logic [1:0] ADC_DIV4 = 2'd1;
    localparam logic [1:0] ADC_DIV6 = 2'd2;
    localparam logic [1:0] ADC_DIV8 = 2'd3;

    localparam logic [CENT_W-1:0] CENT      = 7'd100;
    localparam logic [10:0]       ROUND_ADD = 11'd50;
    localparam logic [12:0]       CENT_RECIP = 13'd5243;
    localparam logic [30:0]       CENT_INV  = 31'h51EB851F;
    localparam logic [31:0]       THIRD_RECIP = 32'hAAAAAAAB;
    localparam logic [5:0]        SCALE_MUL = 6'd25;

    typedef struct packed {
        logic [BAUD_W-1:0] baud_rate;
        logic              oversample_by_eight;
        logic              use_fast_bus;
    } bdiv_req_t;

    typedef struct packed {
        logic [HZ_W-1:0]  system_hz;
        logic [HZ_W-1:0]  ahb_hz;
        logic [HZ_W-1:0]  apb1_hz;
        logic [HZ_W-1:0]  apb2_hz;
        logic [ADC_W-1:0] adc_hz;
        logic [DIV_W-1:0] divisor_word;
        logic             rate_error;
    } bdiv_rsp_t;

    typedef struct packed {
        logic [HZ_W-1:0]  system_hz;
        logic [HZ_W-1:0]  ahb_hz;
        logic [HZ_W-1:0]  apb1_hz;
        logic [HZ_W-1:0]  apb2_hz;
        logic [ADC_W-1:0] adc_hz;
        logic             over8;
        logic             rate_error;
    } bdiv_meta_t;

    function automatic logic [3:0] bus_shift(input logic [3:0] code);
        logic [3:0] sh;
        case (code)
            4'd4:    sh = 4'd1;
            4'd5:    sh = 4'd2;
            4'd6:    sh = 4'd3;
            4'd7:    sh = 4'd4;
            4'd8:    sh = 4'd1;
            4'd9:    sh = 4'd2;
            4'd10:   sh = 4'd3;
            4'd11:   sh = 4'd4;
            4'd12:   sh = 4'd6;
            4'd13:   sh = 4'd7;
            4'd14:   sh = 4'd8;
            4'd15:   sh = 4'd9;
            default: sh = 4'd0;
        endcase
        return sh;
    endfunction

endpackage

>>> rtl/baud_divisor_from_clock_tree_top.sv
// baud divisor top: clock word decode, divider pipeline and output register
// one request per cycle sustained while the response is not stalled; a request passes
// three decode stages, the 33-stage bit-per-stage divider, three reciprocal
// stages for the divide by 100 and the output register
// a stalled response holds the whole pipeline; async active-low reset clears
// valid bits and the clock word
module baud_divisor_from_clock_tree_top #(
    parameter int INTERNAL_OSC_HZ = 8000000,
    parameter int EXTERNAL_OSC_HZ = 8000000
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  bdiv_pkg::bdiv_req_t  req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output bdiv_pkg::bdiv_rsp_t  rsp,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [0:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import bdiv_pkg::*;

    localparam logic [HZ_W-1:0] INT_HZ  = HZ_W'(INTERNAL_OSC_HZ);
    localparam logic [HZ_W-1:0] EXT_HZ  = HZ_W'(EXTERNAL_OSC_HZ);
    localparam logic [HZ_W-1:0] INT_HALF = HZ_W'(INTERNAL_OSC_HZ / 2);
    localparam logic [HZ_W-1:0] EXT_HALF = HZ_W'(EXTERNAL_OSC_HZ / 2);

    logic [CFG_W-1:0] cfg_reg;
    logic             adv;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? cfg_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && paddr == 1'b0)
        begin
            cfg_reg <= pwdata;
        end
    end

    // stage 1: system clock
    logic            s1_v_reg;
    bdiv_req_t       s1_req_reg;
    logic [HZ_W-1:0] s1_sys_reg;
    logic [HZ_W-1:0] sys_next;
    logic [HZ_W-1:0] pll_base;
    logic [4:0]      pll_mul;
    logic [32:0]     pll_prod;

    always_comb
    begin
        pll_mul = {1'b0, cfg_reg[21:18]} + 5'd2;
        if (!cfg_reg[16])
        begin
            pll_base = INT_HALF;
        end
        else if (cfg_reg[17])
        begin
            pll_base = EXT_HALF;
        end
        else
        begin
            pll_base = EXT_HZ;
        end
        pll_prod = 33'(pll_base) * 33'(pll_mul);
        case (cfg_reg[3:2])
            SRC_EXT: sys_next = EXT_HZ;
            SRC_PLL: sys_next = pll_prod[HZ_W-1:0];
            default: sys_next = INT_HZ;
        endcase
    end

    // stage 2: bus clocks
    logic            s2_v_reg;
    bdiv_req_t       s2_req_reg;
    logic [HZ_W-1:0] s2_sys_reg;
    logic [HZ_W-1:0] s2_ahb_reg;
    logic [HZ_W-1:0] s2_apb1_reg;
    logic [HZ_W-1:0] s2_apb2_reg;
    logic [HZ_W-1:0] ahb_next;

    assign ahb_next = s1_sys_reg >> bus_shift(cfg_reg[7:4]);

    // stage 3: divider operands and adc clock
    logic             s3_v_reg;
    logic [NUM_W-1:0] s3_num_reg;
    logic [DEN_W-1:0] s3_den_reg;
    bdiv_meta_t       s3_meta_reg;
    logic [HZ_W-1:0]  bus_clk;
    logic [59:0]      third_prod;
    logic [ADC_W-1:0] adc_next;
    bdiv_meta_t       meta_next;

    always_comb
    begin
        bus_clk    = s2_req_reg.use_fast_bus ? s2_apb2_reg : s2_apb1_reg;
        third_prod = 60'(s2_apb2_reg[HZ_W-1:1]) * 60'(THIRD_RECIP);
        case (cfg_reg[15:14])
            ADC_DIV2: adc_next = s2_apb2_reg[HZ_W-1:1];
            ADC_DIV4: adc_next = ADC_W'(s2_apb2_reg[HZ_W-1:2]);
            ADC_DIV6: adc_next = third_prod[59:33];
            ADC_DIV8: adc_next = ADC_W'(s2_apb2_reg[HZ_W-1:3]);
            default:  adc_next = '0;
        endcase
        meta_next.system_hz  = s2_sys_reg;
        meta_next.ahb_hz     = s2_ahb_reg;
        meta_next.apb1_hz    = s2_apb1_reg;
        meta_next.apb2_hz    = s2_apb2_reg;
        meta_next.adc_hz     = adc_next;
        meta_next.over8      = s2_req_reg.oversample_by_eight;
        meta_next.rate_error = (s2_req_reg.baud_rate == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= req_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_req_reg  <= req;
            s1_sys_reg  <= sys_next;
            s2_req_reg  <= s1_req_reg;
            s2_sys_reg  <= s1_sys_reg;
            s2_ahb_reg  <= ahb_next;
            s2_apb1_reg <= ahb_next >> bus_shift({1'b0, cfg_reg[10:8]});
            s2_apb2_reg <= ahb_next >> bus_shift({1'b0, cfg_reg[13:11]});
            s3_num_reg  <= NUM_W'(bus_clk) * NUM_W'(SCALE_MUL);
            s3_den_reg  <= s2_req_reg.oversample_by_eight
                           ? {1'b0, s2_req_reg.baud_rate, 1'b0}
                           : {s2_req_reg.baud_rate, 2'b00};
            s3_meta_reg <= meta_next;
        end
    end

    // scaled = 25 * clk / (k * baud)
    logic             d1_v;
    logic [NUM_W-1:0] d1_quo;
    logic [DEN_W-1:0] d1_rem;
    bdiv_meta_t       d1_meta;

    bdiv_divpipe #(
        .NW (NUM_W),
        .DW (DEN_W),
        .MW ($bits(bdiv_meta_t))
    ) u_scale_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (s3_v_reg),
        .num      (s3_num_reg),
        .den      (s3_den_reg),
        .meta_in  (s3_meta_reg),
        .out_valid(d1_v),
        .quo      (d1_quo),
        .rem      (d1_rem),
        .meta_out (d1_meta)
    );

    // scaled / 100 by reciprocal, scaled below 2^32 for nonzero baud
    logic              m1_v_reg;
    logic [46:0]       m1_lo_reg;
    logic [46:0]       m1_hi_reg;
    logic [7:0]        m1_byte_reg;
    bdiv_meta_t        m1_meta_reg;
    logic              m2_v_reg;
    logic [11:0]       m2_mant_reg;
    logic [7:0]        m2_byte_reg;
    bdiv_meta_t        m2_meta_reg;
    logic              d2_v_reg;
    logic [11:0]       d2_quo_reg;
    logic [CENT_W-1:0] d2_rem_reg;
    bdiv_meta_t        d2_meta_reg;
    logic [46:0]       lo_next;
    logic [46:0]       hi_next;
    logic [63:0]       recip_sum;
    logic [14:0]       cent_prod;
    logic [7:0]        rem_next;

    always_comb
    begin
        lo_next   = 47'(d1_quo[15:0]) * 47'(CENT_INV);
        hi_next   = 47'(d1_quo[31:16]) * 47'(CENT_INV);
        recip_sum = 64'({m1_hi_reg, 16'h0000}) + 64'(m1_lo_reg);
        cent_prod = 15'(m2_mant_reg[7:0]) * 15'(CENT);
        rem_next  = m2_byte_reg - cent_prod[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            d2_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_v_reg <= d1_v;
            m2_v_reg <= m1_v_reg;
            d2_v_reg <= m2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_lo_reg   <= lo_next;
            m1_hi_reg   <= hi_next;
            m1_byte_reg <= d1_quo[7:0];
            m1_meta_reg <= d1_meta;
            m2_mant_reg <= recip_sum[48:37];
            m2_byte_reg <= m1_byte_reg;
            m2_meta_reg <= m1_meta_reg;
            d2_quo_reg  <= m2_mant_reg;
            d2_rem_reg  <= rem_next[CENT_W-1:0];
            d2_meta_reg <= m2_meta_reg;
        end
    end

    // fraction rounding and output register
    logic        rsp_valid_reg;
    bdiv_rsp_t   rsp_reg;
    bdiv_rsp_t   rsp_next;
    logic [10:0] frac_scaled;
    logic [23:0] frac_prod;
    logic [4:0]  frac_q;
    logic        frac_carry;
    logic [11:0] mant_low;

    always_comb
    begin
        frac_scaled = d2_meta_reg.over8 ? ({1'b0, d2_rem_reg, 3'b000} + ROUND_ADD)
                                        : ({d2_rem_reg, 4'b0000} + ROUND_ADD);
        frac_prod   = 24'(frac_scaled) * 24'(CENT_RECIP);
        frac_q      = frac_prod[23:19];
        frac_carry  = d2_meta_reg.over8 ? (frac_q >= 5'd8) : (frac_q >= 5'd16);
        mant_low    = d2_quo_reg + 12'(frac_carry);
        rsp_next.system_hz    = d2_meta_reg.system_hz;
        rsp_next.ahb_hz       = d2_meta_reg.ahb_hz;
        rsp_next.apb1_hz      = d2_meta_reg.apb1_hz;
        rsp_next.apb2_hz      = d2_meta_reg.apb2_hz;
        rsp_next.adc_hz       = d2_meta_reg.adc_hz;
        rsp_next.rate_error   = d2_meta_reg.rate_error;
        if (d2_meta_reg.rate_error)
        begin
            rsp_next.divisor_word = '0;
        end
        else
        begin
            rsp_next.divisor_word = {mant_low, frac_carry ? 4'd0 : frac_q[3:0]};
        end
    end

    assign adv = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rsp_valid_reg <= d2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign req_ready = adv;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_err_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.rate_error |-> rsp.divisor_word == '0)
        else $error("divisor not cleared on zero baud rate");

    a_adc_below_apb2: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> {1'b0, rsp.adc_hz} <= rsp.apb2_hz)
        else $error("adc clock above apb2 clock");

    a_bus_below_ahb: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.apb1_hz <= rsp.ahb_hz && rsp.apb2_hz <= rsp.ahb_hz
                      && rsp.ahb_hz <= rsp.system_hz)
        else $error("bus clock above its parent clock");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request refused with empty output register");

endmodule

>>> rtl/bdiv_divpipe.sv
// bdiv_divpipe: restoring divider, one quotient bit per register stage,
// with a sideband word carried alongside; does not depend on bdiv_pkg
module bdiv_divpipe #(
    parameter int NW = 33,
    parameter int DW = 25,
    parameter int MW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [MW-1:0] meta_in,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem,
    output logic [MW-1:0] meta_out
);

    logic [NW-1:0] v_reg;
    logic [NW-1:0] v_next;
    logic [DW-1:0] rem_reg  [NW];
    logic [NW-1:0] quo_reg  [NW];
    logic [NW-1:0] num_reg  [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [MW-1:0] meta_reg [NW];

    logic [DW-1:0] prem  [NW];
    logic [NW-1:0] pquo  [NW];
    logic [NW-1:0] pnum  [NW];
    logic [DW-1:0] pden  [NW];
    logic [MW-1:0] pmeta [NW];
    logic [DW:0]   trial [NW];
    logic [DW:0]   diff  [NW];
    logic [NW-1:0] fits;

    logic [DW-1:0] rem_next [NW];
    logic [NW-1:0] quo_next [NW];
    logic [NW-1:0] num_next [NW];

    always_comb
    begin
        for (int i = 0; i < NW; i++)
        begin
            if (i == 0)
            begin
                v_next[i] = in_valid;
                prem[i]   = '0;
                pquo[i]   = '0;
                pnum[i]   = num;
                pden[i]   = den;
                pmeta[i]  = meta_in;
            end
            else
            begin
                v_next[i] = v_reg[i-1];
                prem[i]   = rem_reg[i-1];
                pquo[i]   = quo_reg[i-1];
                pnum[i]   = num_reg[i-1];
                pden[i]   = den_reg[i-1];
                pmeta[i]  = meta_reg[i-1];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NW; i++)
        begin
            trial[i]    = {prem[i], pnum[i][NW-1]};
            diff[i]     = trial[i] - {1'b0, pden[i]};
            fits[i]     = trial[i] >= {1'b0, pden[i]};
            rem_next[i] = fits[i] ? diff[i][DW-1:0] : trial[i][DW-1:0];
            quo_next[i] = {pquo[i][NW-2:0], fits[i]};
            num_next[i] = {pnum[i][NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NW; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                quo_reg[i]  <= quo_next[i];
                num_reg[i]  <= num_next[i];
                den_reg[i]  <= pden[i];
                meta_reg[i] <= pmeta[i];
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign quo       = quo_reg[NW-1];
    assign rem       = rem_reg[NW-1];
    assign meta_out  = meta_reg[NW-1];

endmodule

>>> verif/tb_top.sv
// tb_top: self-checking testbench for baud_divisor_from_clock_tree_top
// drives baud requests and clock-word register writes, predicts every response
// depends on bdiv_pkg and the top-level rtl
module tb_top;
    import bdiv_pkg::*;

    localparam int LATENCY   = 40;
    localparam int MAX_CYCLE = 400000;
    localparam logic [0:0] ADDR_CLOCK_CFG = 1'b0;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    bdiv_req_t req;
    logic rsp_valid;
    logic rsp_ready;
    bdiv_rsp_t rsp;
    logic psel;
    logic penable;
    logic pwrite;
    logic [0:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    baud_divisor_from_clock_tree_top uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    bdiv_req_t pending_reqs[$];
    bdiv_rsp_t expected_rsps[$];
    logic [31:0] clock_word;
    int send_idle_pct;
    int recv_idle_pct;
    int mismatches = 0;
    int rsp_count = 0;
    int cycle_count = 0;
    int cfg_count = 0;
    logic apb_go;
    logic [31:0] apb_value;
    logic apb_done;
    int apb_phase;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [3:0] shift_of(input logic [3:0] code);
        logic [3:0] s;
        if (code < 4'd4)
            s = 4'd0;
        else if (code < 4'd8)
            s = code - 4'd3;
        else if (code < 4'd12)
            s = code - 4'd7;
        else
            s = code - 4'd6;
        return s;
    endfunction

    function automatic bdiv_rsp_t predict_divisor(input logic [31:0] w, input bdiv_req_t r);
        bdiv_rsp_t o;
        logic [63:0] sys;
        logic [63:0] ahb;
        logic [63:0] apb1;
        logic [63:0] apb2;
        logic [63:0] bus;
        logic [63:0] base;
        logic [63:0] scaled;
        logic [63:0] mant;
        logic [63:0] frac;
        logic [63:0] word;
        logic [63:0] osc;
        osc = 64'd8000000;
        if (w[3:2] == SRC_EXT)
            sys = osc;
        else if (w[3:2] != SRC_PLL)
            sys = osc;
        else
        begin
            if (!w[16])
                base = osc >> 1;
            else if (w[17])
                base = osc >> 1;
            else
                base = osc;
            sys = (base * (64'(w[21:18]) + 2)) & 64'h0FFFFFFF;
        end
        ahb = sys >> shift_of(w[7:4]);
        apb1 = ahb >> shift_of({1'b0, w[10:8]});
        apb2 = ahb >> shift_of({1'b0, w[13:11]});
        o.system_hz = sys[HZ_W-1:0];
        o.ahb_hz = ahb[HZ_W-1:0];
        o.apb1_hz = apb1[HZ_W-1:0];
        o.apb2_hz = apb2[HZ_W-1:0];
        o.adc_hz = ADC_W'(apb2 / (2 * (64'(w[15:14]) + 1)));
        bus = r.use_fast_bus ? apb2 : apb1;
        o.divisor_word = '0;
        o.rate_error = 1'b0;
        if (r.baud_rate == 0)
            o.rate_error = 1'b1;
        else
        begin
            if (r.oversample_by_eight)
                scaled = (25 * bus) / (2 * 64'(r.baud_rate));
            else
                scaled = (25 * bus) / (4 * 64'(r.baud_rate));
            mant = scaled / 100;
            frac = scaled - 100 * mant;
            if (r.oversample_by_eight)
            begin
                frac = (frac * 8 + 50) / 100;
                if (frac >= 8)
                begin
                    mant = mant + 1;
                    frac = 0;
                end
            end
            else
            begin
                frac = (frac * 16 + 50) / 100;
                if (frac >= 16)
                begin
                    mant = mant + 1;
                    frac = 0;
                end
            end
            word = (mant << 4) + frac;
            o.divisor_word = word[15:0];
        end
        return o;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else if (!req_valid || req_ready)
        begin
            if (req_valid && req_ready)
                expected_rsps.push_back(predict_divisor(clock_word, req));
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                rsp_count <= rsp_count + 1;
                if (expected_rsps.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected response %h", rsp);
                end
                else
                begin
                    bdiv_rsp_t e;
                    e = expected_rsps.pop_front();
                    if (rsp.system_hz !== e.system_hz || rsp.ahb_hz !== e.ahb_hz
                        || rsp.apb1_hz !== e.apb1_hz || rsp.apb2_hz !== e.apb2_hz
                        || rsp.adc_hz !== e.adc_hz || rsp.divisor_word !== e.divisor_word
                        || rsp.rate_error !== e.rate_error)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch word %h: expected %h actual %h",
                                     clock_word, e, rsp);
                    end
                end
            end
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // apb write sequencer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            paddr <= ADDR_CLOCK_CFG;
            pwdata <= '0;
            apb_phase <= 0;
            apb_done <= 1'b0;
            clock_word <= '0;
        end
        else if (apb_phase == 0 && apb_go && !apb_done)
        begin
            psel <= 1'b1;
            pwrite <= 1'b1;
            paddr <= ADDR_CLOCK_CFG;
            pwdata <= apb_value;
            apb_phase <= 1;
        end
        else if (apb_phase == 1)
        begin
            penable <= 1'b1;
            apb_phase <= 2;
        end
        else if (apb_phase == 2 && pready)
        begin
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            clock_word <= pwdata;
            apb_done <= 1'b1;
            apb_phase <= 0;
        end
        else if (!apb_go)
            apb_done <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_clock_word(input logic [31:0] value);
        wait_drained();
        apb_value = value;
        apb_go = 1'b1;
        while (!apb_done)
            @(posedge clk);
        apb_go = 1'b0;
        @(posedge clk);
        cfg_count++;
    endtask

    function automatic bdiv_req_t random_req();
        bdiv_req_t r;
        case ($urandom_range(9))
            0: r.baud_rate = BAUD_W'($urandom_range(4500000));
            1: r.baud_rate = BAUD_W'($urandom_range(50));
            2: r.baud_rate = {BAUD_W{1'b1}} - BAUD_W'($urandom_range(100));
            3: r.baud_rate = BAUD_W'($urandom);
            default: r.baud_rate = BAUD_W'($urandom_range(1200, 921600));
        endcase
        r.oversample_by_eight = 1'($urandom_range(1));
        r.use_fast_bus = 1'($urandom_range(1));
        return r;
    endfunction

    function automatic logic [31:0] random_clock_word();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(2) != 0)
            w[3:2] = SRC_PLL;
        return w;
    endfunction

    initial
    begin
        logic [31:0] words[6];
        bdiv_req_t r;
        rst_n = 1'b0;
        apb_go = 1'b0;
        apb_value = '0;
        send_idle_pct = 14;
        recv_idle_pct = 64;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset word, field extremes, zero baud, rounding carry
        for (int i = 0; i < 8; i++)
        begin
            r.baud_rate = (i < 2) ? BAUD_W'(0) : (i < 4) ? {BAUD_W{1'b1}}
                        : (i < 6) ? BAUD_W'(1) : BAUD_W'(115200);
            r.oversample_by_eight = i[0];
            r.use_fast_bus = i[1];
            pending_reqs.push_back(r);
        end
        words = '{32'h003C_0008, 32'hFFFF_FFFF, 32'h0001_0008, 32'h0003_0008,
                  32'h0000_000C, 32'h0000_0004};
        foreach (words[k])
        begin
            write_clock_word(words[k]);
            for (int i = 0; i < 3; i++)
            begin
                r.baud_rate = (i == 0) ? BAUD_W'(0) : (i == 1) ? BAUD_W'(9600) : BAUD_W'(1);
                r.oversample_by_eight = i[0];
                r.use_fast_bus = ~i[0];
                pending_reqs.push_back(r);
            end
        end

        // random phases with changing clock words
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 4)
            begin
                send_idle_pct = 64;
                recv_idle_pct = 14;
            end
            if (ph == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_clock_word(random_clock_word());
            for (int i = 0; i < 50; i++)
            begin
                pending_reqs.push_back(random_req());
                if (ph == 6 && i == 25)
                begin
                    while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
                        @(posedge clk);
                end
            end
        end
        wait_drained();

        $display("covered %0d responses over %0d clock word settings", rsp_count, cfg_count);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/bdiv_pkg.sv
rtl/bdiv_divpipe.sv
rtl/baud_divisor_from_clock_tree_top.sv
verif/tb_top.sv
